### sv/rgb_to_nv12_converter_assert.svh
// Assertion macros for the RGB to NV12 converter.
// Used inside modules that have clk and rst_n in scope; no other dependencies.
`ifndef RGB_TO_NV12_CONVERTER_ASSERT_SVH
`define RGB_TO_NV12_CONVERTER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RNV12_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define RNV12_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rgbnv12_pkg.sv
// Shared types and constants for the RGB to NV12 converter.
// No dependencies; imported by rgb_to_nv12_converter.
`default_nettype none

package rgbnv12_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PADDR_W = 4;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    // Pixel format codes; unused code reads as blue green red
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_BGR  = 2'd2;

    localparam logic [1:0]  PIXEL_FORMAT_RST = FMT_RGB;
    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic KIND_LUMA   = 1'b0;
    localparam logic KIND_CHROMA = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [7:0] byte_third;
    } pixel_item_t;

    typedef struct packed {
        logic        sample_kind;
        logic [7:0]  value_a;
        logic [7:0]  value_b;
        logic [11:0] out_column;
        logic [11:0] out_row;
        logic        last_of_item;
        logic        frame_end;
        logic        status;
    } result_item_t;

endpackage

`default_nettype wire

### sv/rgb_to_nv12_converter.sv
// RGB to NV12 converter top level: register port, term stage, line store, result buffer.
// Depends on rgbnv12_pkg and rgb_to_nv12_converter_assert.svh.
`default_nettype none

// One pixel is taken per clock in raster order when nothing stalls. A pixel is
// registered in the term stage (luma, U and V terms from the three bytes) and
// then moves into the result register, where its luma result is offered; for
// the bottom-right pixel of each 2x2 block in colour mode a chroma result waits
// and follows on the single result port once the luma result is taken, with
// input stalled meanwhile, so intake slows over colour odd rows. The line
// store is a synchronous memory of MAX_WIDTH/2 entries of 18 bits holding the
// U and V pair sums of the even row, read when a pixel is taken and written
// when that pixel leaves the term stage; it needs no clearing after reset. A
// write to any of the three registers restarts the frame at column 0, row 0.
// Zero, odd or oversized width or height gives one status result per pixel.
module rgb_to_nv12_converter #(
    parameter int MAX_WIDTH  = rgbnv12_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbnv12_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pix_valid,
    output logic                                   pix_ready,
    input  wire rgbnv12_pkg::pixel_item_t          pix_data,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output rgbnv12_pkg::result_item_t              res_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rgbnv12_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import rgbnv12_pkg::*;

    localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW         = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LIDX_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // ---------------- register port ----------------
    logic [1:0]  fmt_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_hit = cfg_wr && (cfg_idx inside {REG_PIXEL_FORMAT, REG_FRAME_WIDTH,
                                                REG_FRAME_HEIGHT});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= PIXEL_FORMAT_RST;
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PIXEL_FORMAT: fmt_reg    <= pwdata[1:0];
                REG_FRAME_WIDTH:  width_reg  <= pwdata[12:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PIXEL_FORMAT: prdata = 32'(fmt_reg);
            REG_FRAME_WIDTH:  prdata = 32'(width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = 32'd0;
        endcase
    end

    logic geom_ok;
    assign geom_ok = (width_reg != 13'd0) && !width_reg[0] &&
                     (14'(width_reg) <= 14'(MAX_WIDTH)) &&
                     (height_reg != 13'd0) && !height_reg[0] &&
                     (14'(height_reg) <= 14'(MAX_HEIGHT));

    // ---------------- handshake control ----------------
    logic s1_valid_reg;
    logic s1_move;
    logic pix_take;
    logic out_valid_reg;
    logic pend_valid_reg;

    assign s1_move   = s1_valid_reg && !pend_valid_reg && (!out_valid_reg || res_ready);
    assign pix_ready = !s1_valid_reg || s1_move;
    assign pix_take  = pix_valid && pix_ready;

    // ---------------- position counters ----------------
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [13:0]   col_inc;
    logic [13:0]   row_inc;
    logic          row_wrap;
    logic          col_wrap;

    assign col_inc  = 14'(col_reg) + 14'd1;
    assign row_inc  = 14'(row_reg) + 14'd1;
    assign col_wrap = col_inc >= 14'(width_reg);
    assign row_wrap = row_inc >= 14'(height_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : RW'(row_inc);
        end
        else
        begin
            col_next = CW'(col_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_take && geom_ok)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- term stage (computed at intake) ----------------
    logic [7:0]         r_in;
    logic [7:0]         g_in;
    logic [7:0]         b_in;
    logic               gray_in;
    logic [15:0]        luma_sum;
    logic [8:0]         luma_off;
    logic [7:0]         luma_in;
    logic [15:0]        u_pos;
    logic [15:0]        u_neg;
    logic [15:0]        v_pos;
    logic [15:0]        v_neg;
    logic signed [16:0] u_sum;
    logic signed [16:0] v_sum;
    logic signed [16:0] u_shr;
    logic signed [16:0] v_shr;
    logic [7:0]         ut_in;
    logic [7:0]         vt_in;

    assign gray_in = (fmt_reg == FMT_GRAY);

    always_comb
    begin
        case (fmt_reg)
            FMT_GRAY:
            begin
                r_in = pix_data.byte_first;
                g_in = pix_data.byte_first;
                b_in = pix_data.byte_first;
            end
            FMT_RGB:
            begin
                r_in = pix_data.byte_first;
                g_in = pix_data.byte_second;
                b_in = pix_data.byte_third;
            end
            default:
            begin
                r_in = pix_data.byte_third;
                g_in = pix_data.byte_second;
                b_in = pix_data.byte_first;
            end
        endcase
    end

    assign luma_sum = 16'(r_in) * 16'd66 + 16'(g_in) * 16'd129 + 16'(b_in) * 16'd25 +
                      16'd128;
    assign luma_off = {1'b0, luma_sum[15:8]} + 9'd16;
    assign luma_in  = gray_in ? pix_data.byte_first :
                      (luma_off[8] ? 8'hFF : luma_off[7:0]);

    assign u_pos = 16'(b_in) * 16'd112 + 16'd128;
    assign u_neg = 16'(r_in) * 16'd38 + 16'(g_in) * 16'd74;
    assign v_pos = 16'(r_in) * 16'd112 + 16'd128;
    assign v_neg = 16'(g_in) * 16'd94 + 16'(b_in) * 16'd18;
    assign u_sum = $signed({1'b0, u_pos}) - $signed({1'b0, u_neg});
    assign v_sum = $signed({1'b0, v_pos}) - $signed({1'b0, v_neg});
    assign u_shr = u_sum >>> 8;
    assign v_shr = v_sum >>> 8;
    // floor term plus 128 lands in 16..240, so the low byte is exact
    assign ut_in = u_shr[7:0] + 8'd128;
    assign vt_in = v_shr[7:0] + 8'd128;

    logic          fend_in;
    assign fend_in = col_wrap && row_wrap;

    logic [7:0]    s1_luma_reg;
    logic [7:0]    s1_ut_reg;
    logic [7:0]    s1_vt_reg;
    logic [CW-1:0] s1_x_reg;
    logic [RW-1:0] s1_y_reg;
    logic          s1_fend_reg;
    logic          s1_bad_reg;
    logic          s1_gray_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            s1_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            s1_luma_reg <= luma_in;
            s1_ut_reg   <= ut_in;
            s1_vt_reg   <= vt_in;
            s1_x_reg    <= col_reg;
            s1_y_reg    <= row_reg;
            s1_fend_reg <= fend_in;
            s1_bad_reg  <= !geom_ok;
            s1_gray_reg <= gray_in;
        end
    end

    // ---------------- line store ----------------
    // An entry is written on an even row and read back one full row later, at
    // least two pixels on, so a read never overlaps a pending write of its entry.
    logic [17:0]       line_mem [LINE_DEPTH];
    logic [17:0]       rd_data_reg;
    logic [LIDX_W-1:0] rd_addr;
    logic [LIDX_W-1:0] wr_addr;
    logic [13:0]       col_ext;
    logic [13:0]       s1_x_ext;
    logic              wr_en;
    logic [17:0]       wr_data;

    assign col_ext  = 14'(col_reg);
    assign s1_x_ext = 14'(s1_x_reg);
    assign rd_addr  = col_ext[LIDX_W:1];
    assign wr_addr  = s1_x_ext[LIDX_W:1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (pix_take)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    // ---------------- pair and block sums (at stage exit) ----------------
    logic [15:0] left_terms_reg;
    logic [8:0]  u_pair;
    logic [8:0]  v_pair;
    logic [10:0] u_quad;
    logic [10:0] v_quad;
    logic [7:0]  u_avg;
    logic [7:0]  v_avg;
    logic        x_odd;
    logic        y_odd;
    logic        chroma_out;

    assign x_odd  = s1_x_reg[0];
    assign y_odd  = s1_y_reg[0];
    assign u_pair = {1'b0, left_terms_reg[7:0]} + {1'b0, s1_ut_reg};
    assign v_pair = {1'b0, left_terms_reg[15:8]} + {1'b0, s1_vt_reg};
    assign u_quad = 11'(u_pair) + 11'(rd_data_reg[8:0]) + 11'd2;
    assign v_quad = 11'(v_pair) + 11'(rd_data_reg[17:9]) + 11'd2;
    assign u_avg  = u_quad[10] ? 8'hFF : u_quad[9:2];
    assign v_avg  = v_quad[10] ? 8'hFF : v_quad[9:2];

    assign chroma_out = !s1_bad_reg && !s1_gray_reg && x_odd && y_odd;
    assign wr_en      = s1_move && !s1_bad_reg && x_odd && !y_odd;
    assign wr_data    = {v_pair, u_pair};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_terms_reg <= '0;
        end
        else if (s1_move && !s1_bad_reg && !x_odd)
        begin
            left_terms_reg <= {s1_vt_reg, s1_ut_reg};
        end
    end

    // ---------------- result buffer ----------------
    result_item_t luma_res;
    result_item_t chroma_res;
    result_item_t out_reg;
    result_item_t pend_reg;
    logic [11:0]  x12;

    assign x12 = 12'(s1_x_reg);

    always_comb
    begin
        luma_res              = '0;
        luma_res.sample_kind  = KIND_LUMA;
        luma_res.last_of_item = 1'b1;
        if (s1_bad_reg)
        begin
            luma_res.status = STATUS_BAD;
        end
        else
        begin
            luma_res.value_a      = s1_luma_reg;
            luma_res.out_column   = x12;
            luma_res.out_row      = 12'(s1_y_reg);
            luma_res.last_of_item = !chroma_out;
            luma_res.frame_end    = s1_fend_reg;
            luma_res.status       = STATUS_OK;
        end

        chroma_res              = '0;
        chroma_res.sample_kind  = KIND_CHROMA;
        chroma_res.value_a      = u_avg;
        chroma_res.value_b      = v_avg;
        chroma_res.out_column   = {x12[11:1], 1'b0};
        chroma_res.out_row      = 12'(s1_y_reg >> 1);
        chroma_res.last_of_item = 1'b1;
        chroma_res.frame_end    = s1_fend_reg;
        chroma_res.status       = STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= chroma_out;
        end
        else if (res_ready)
        begin
            // advance the waiting chroma result, else drain
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg  <= luma_res;
            pend_reg <= chroma_res;
        end
        else if (res_ready && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // ---------------- assertions ----------------
`include "rgb_to_nv12_converter_assert.svh"

    `RNV12_ASSERT_NOW(a_pend_behind_out, pend_valid_reg, out_valid_reg,
        "chroma result waiting without a result on the port")
    `RNV12_ASSERT_NOW(a_chroma_is_last,
        res_valid && (res_data.sample_kind == KIND_CHROMA),
        res_data.last_of_item && (res_data.status == STATUS_OK),
        "chroma result not marked last or carries bad status")
    `RNV12_ASSERT_NOW(a_luma_not_last_has_pend,
        res_valid && (res_data.sample_kind == KIND_LUMA) && !res_data.last_of_item,
        pend_valid_reg, "luma result announces a chroma result that is not queued")
    `RNV12_ASSERT_NEXT(a_cfg_restarts_frame, cfg_hit,
        (col_reg == '0) && (row_reg == '0), "register write did not restart the frame")
    `RNV12_ASSERT_NOW(a_no_store_write_bad, wr_en, !s1_bad_reg && s1_valid_reg,
        "line store written for a pixel with invalid geometry")

endmodule

`default_nettype wire
